// File: rtl/eth_pkg.sv
// Shared types, codes and helper functions of the edge thinning and hysteresis core.
`timescale 1ns / 1ps
`default_nettype none
package eth_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int DIM_REG_W  = 9;
   localparam int THR_W      = 8;

   localparam logic [DIM_REG_W-1:0] RST_WIDTH  = 9'd256;
   localparam logic [DIM_REG_W-1:0] RST_HEIGHT = 9'd256;
   localparam logic [THR_W-1:0]     RST_HIGH   = 8'd80;
   localparam logic [THR_W-1:0]     RST_LOW    = 8'd20;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW    = 2'd3;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [1:0] CLS_NONE   = 2'd0;
   localparam logic [1:0] CLS_WEAK   = 2'd1;
   localparam logic [1:0] CLS_STRONG = 2'd2;

   localparam logic [1:0] SEC_0   = 2'd0;
   localparam logic [1:0] SEC_45  = 2'd1;
   localparam logic [1:0] SEC_90  = 2'd2;
   localparam logic [1:0] SEC_135 = 2'd3;

   localparam logic [2:0] NB_LAST = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_RSP,
      ST_NMS_CTR,
      ST_NMS_CAP,
      ST_NMS_LO,
      ST_NMS_HI,
      ST_NMS_WR,
      ST_HYS_CTR,
      ST_HYS_CHK,
      ST_HYS_NB,
      ST_DONE
   } eth_state_type;

   typedef enum logic [2:0] {
      ADDR_REQ,
      ADDR_CTR,
      ADDR_NMS_LO,
      ADDR_NMS_HI,
      ADDR_NB
   } eth_addr_sel_type;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } eth_step_type;

   typedef struct packed {
      eth_addr_sel_type addr_sel;
      logic load_wr;
      logic pass_start;
      logic cap_ctr;
      logic chk_lo;
      logic cls_wr;
      logic pix_next;
      logic nb_start;
      logic nb_next;
      logic promote;
      logic frame_done;
      logic edge_clr;
      logic edge_cap;
      logic idx_cap;
      logic rsp_load;
   } eth_cmd_type;

   typedef struct packed {
      logic count_last;
      logic interior;
      logic ctr_weak;
      logic nb_strong;
      logic nb_last;
      logic pix_last;
      logic changed;
      logic out_free;
   } eth_status_type;

   // fold and quantise a direction in degrees to one of four axes
   function automatic logic [1:0] sector_of(input logic [7:0] dir);
      logic [7:0] d;
      logic [1:0] s;
      d = (dir > 8'd180) ? dir - 8'd180 : dir;
      if (d >= 8'd23 && d <= 8'd67) begin
         s = SEC_45;
      end else if (d >= 8'd68 && d <= 8'd112) begin
         s = SEC_90;
      end else if (d >= 8'd113 && d <= 8'd157) begin
         s = SEC_135;
      end else begin
         s = SEC_0;
      end
      return s;
   endfunction

   // positive step along the axis of a sector
   function automatic eth_step_type sector_step(input logic [1:0] s);
      eth_step_type st;
      unique case (s)
         SEC_0:   begin st.dx = 2'sd1;  st.dy = 2'sd0; end
         SEC_45:  begin st.dx = 2'sd1;  st.dy = 2'sd1; end
         SEC_90:  begin st.dx = 2'sd0;  st.dy = 2'sd1; end
         default: begin st.dx = -2'sd1; st.dy = 2'sd1; end
      endcase
      return st;
   endfunction

   // eight neighbours in raster order
   function automatic eth_step_type nb_step(input logic [2:0] n);
      eth_step_type st;
      unique case (n)
         3'd0:    begin st.dx = -2'sd1; st.dy = -2'sd1; end
         3'd1:    begin st.dx = 2'sd0;  st.dy = -2'sd1; end
         3'd2:    begin st.dx = 2'sd1;  st.dy = -2'sd1; end
         3'd3:    begin st.dx = -2'sd1; st.dy = 2'sd0;  end
         3'd4:    begin st.dx = 2'sd1;  st.dy = 2'sd0;  end
         3'd5:    begin st.dx = -2'sd1; st.dy = 2'sd1;  end
         3'd6:    begin st.dx = 2'sd0;  st.dy = 2'sd1;  end
         default: begin st.dx = 2'sd1;  st.dy = 2'sd1;  end
      endcase
      return st;
   endfunction

endpackage
`default_nettype wire

// File: rtl/eth_ctrl.sv
// Sequencer of the edge core: beat handling, suppression scan and hysteresis passes.
`timescale 1ns / 1ps
`default_nettype none
module eth_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire                     action,
   input  eth_pkg::eth_status_type status,
   output eth_pkg::eth_cmd_type    cmd
);
   import eth_pkg::*;

   eth_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic pix_end;
      pix_end    = 1'b0;
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.addr_sel = ADDR_CTR;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (action == ACT_READ) begin
                  cmd.addr_sel = ADDR_REQ;
                  cmd.idx_cap  = 1'b1;
                  state_in     = ST_RD;
               end else begin
                  cmd.load_wr  = 1'b1;
                  cmd.edge_clr = 1'b1;
                  if (status.count_last) begin
                     cmd.pass_start = 1'b1;
                     state_in       = ST_NMS_CTR;
                  end else begin
                     state_in = ST_RSP;
                  end
               end
            end
         end
         ST_RD: begin
            cmd.edge_cap = 1'b1;
            state_in     = ST_RSP;
         end
         ST_RSP: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_NMS_CTR: begin
            cmd.addr_sel = ADDR_CTR;
            state_in     = ST_NMS_CAP;
         end
         ST_NMS_CAP: begin
            cmd.cap_ctr = 1'b1;
            state_in    = ST_NMS_LO;
         end
         ST_NMS_LO: begin
            cmd.addr_sel = ADDR_NMS_LO;
            state_in     = ST_NMS_HI;
         end
         ST_NMS_HI: begin
            cmd.addr_sel = ADDR_NMS_HI;
            cmd.chk_lo   = 1'b1;
            state_in     = ST_NMS_WR;
         end
         ST_NMS_WR: begin
            cmd.cls_wr = 1'b1;
            if (status.pix_last) begin
               cmd.pass_start = 1'b1;
               state_in       = ST_HYS_CTR;
            end else begin
               cmd.pix_next = 1'b1;
               state_in     = ST_NMS_CTR;
            end
         end
         ST_HYS_CTR: begin
            cmd.addr_sel = ADDR_CTR;
            state_in     = ST_HYS_CHK;
         end
         ST_HYS_CHK: begin
            cmd.addr_sel = ADDR_NB;
            if (status.interior && status.ctr_weak) begin
               cmd.nb_start = 1'b1;
               state_in     = ST_HYS_NB;
            end else begin
               pix_end = 1'b1;
            end
         end
         ST_HYS_NB: begin
            cmd.addr_sel = ADDR_NB;
            if (status.nb_strong) begin
               cmd.promote = 1'b1;
               pix_end     = 1'b1;
            end else if (status.nb_last) begin
               pix_end = 1'b1;
            end else begin
               cmd.nb_next = 1'b1;
            end
         end
         ST_DONE: begin
            cmd.frame_done = 1'b1;
            state_in       = ST_RSP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // close the pixel: next pixel, another pass, or finish
      if (pix_end) begin
         if (status.pix_last) begin
            if (status.changed || cmd.promote) begin
               cmd.pass_start = 1'b1;
               state_in       = ST_HYS_CTR;
            end else begin
               state_in = ST_DONE;
            end
         end else begin
            cmd.pix_next = 1'b1;
            state_in     = ST_HYS_CTR;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/eth_dp.sv
// Datapath of the edge core: frame memories, scan counters, compares and result register.
`timescale 1ns / 1ps
`default_nettype none
module eth_dp #(
   parameter  int MAX_WIDTH  = eth_pkg::DEF_MAX_WIDTH,
   parameter  int MAX_HEIGHT = eth_pkg::DEF_MAX_HEIGHT,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  eth_pkg::eth_cmd_type         cmd,
   output eth_pkg::eth_status_type      status,
   input  wire [7:0]                    magnitude,
   input  wire [7:0]                    direction,
   input  wire [15:0]                   pixel_index,
   input  wire [WW-1:0]                 w_eff,
   input  wire [HW-1:0]                 h_eff,
   input  wire [eth_pkg::THR_W-1:0]     high_threshold,
   input  wire [eth_pkg::THR_W-1:0]     low_threshold,
   input  wire                          rsp_tready,
   output logic                         rsp_tvalid,
   output logic [eth_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import eth_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int IW    = (AW + 1 > 16) ? AW + 1 : 16;

   logic [9:0]    ms_mem  [DEPTH];
   logic [1:0]    cls_mem [DEPTH];
   logic [9:0]    rd_ms_ff;
   logic [1:0]    rd_cls_ff;
   logic [AW-1:0] rd_addr;

   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [AW-1:0] ctr_ff;
   logic [AW:0]   cnt_ff;
   logic          ready_ff;
   logic          changed_ff;
   logic [7:0]    m_ff;
   logic [1:0]    s_ff;
   logic          supp_ff;
   logic [2:0]    nb_ff;
   logic          edge_ff;
   logic          idx_ok_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_data_ff;

   logic [AW:0]   area;
   logic [AW:0]   cnt_inc;
   logic          x_last;
   logic          y_last;
   eth_step_type  step_hi;
   eth_step_type  step_lo;
   eth_step_type  step_nb;
   logic [2:0]    nb_issue;
   logic          lo_ok;
   logic          hi_ok;
   logic [7:0]    keep;
   logic [1:0]    cls_val;
   logic          cls_we;
   logic [1:0]    cls_wdata;

   function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] c,
                                                input logic [WW-1:0] w,
                                                input eth_step_type st);
      logic [AW-1:0] b;
      if (st.dy < 0) begin
         b = c - AW'(w);
      end else if (st.dy > 0) begin
         b = c + AW'(w);
      end else begin
         b = c;
      end
      if (st.dx < 0) begin
         b = b - AW'(1);
      end else if (st.dx > 0) begin
         b = b + AW'(1);
      end
      return b;
   endfunction

   function automatic logic step_in_frame(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                          input logic xl, input logic yl,
                                          input eth_step_type st);
      return !((st.dx < 0) && (x == '0)) && !((st.dx > 0) && xl) &&
             !((st.dy < 0) && (y == '0)) && !((st.dy > 0) && yl);
   endfunction

   assign area    = (AW + 1)'(w_eff) * (AW + 1)'(h_eff);
   assign cnt_inc = cnt_ff + (AW + 1)'(1);
   assign x_last  = (WW'(x_ff) == w_eff - WW'(1));
   assign y_last  = (HW'(y_ff) == h_eff - HW'(1));

   assign step_hi  = sector_step(s_ff);
   assign step_lo  = '{dx: -step_hi.dx, dy: -step_hi.dy};
   assign nb_issue = cmd.nb_start ? 3'd0 : nb_ff + 3'd1;
   assign step_nb  = nb_step(nb_issue);
   assign lo_ok    = step_in_frame(x_ff, y_ff, x_last, y_last, step_lo);
   assign hi_ok    = step_in_frame(x_ff, y_ff, x_last, y_last, step_hi);

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_REQ:    rd_addr = AW'(pixel_index);
         ADDR_NMS_LO: rd_addr = step_addr(ctr_ff, w_eff, step_lo);
         ADDR_NMS_HI: rd_addr = step_addr(ctr_ff, w_eff, step_hi);
         ADDR_NB:     rd_addr = step_addr(ctr_ff, w_eff, step_nb);
         default:     rd_addr = ctr_ff;
      endcase
   end

   // suppressed magnitude of the centre, then threshold it
   always_comb begin
      keep = (supp_ff || (hi_ok && (rd_ms_ff[7:0] > m_ff))) ? 8'd0 : m_ff;
      if (keep >= high_threshold) begin
         cls_val = CLS_STRONG;
      end else if (keep >= low_threshold) begin
         cls_val = CLS_WEAK;
      end else begin
         cls_val = CLS_NONE;
      end
   end

   assign cls_we    = cmd.cls_wr || cmd.promote;
   assign cls_wdata = cmd.promote ? CLS_STRONG : cls_val;

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         ms_mem[cnt_ff[AW-1:0]] <= {sector_of(direction), magnitude};
      end
      rd_ms_ff <= ms_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[ctr_ff] <= cls_wdata;
      end
      rd_cls_ff <= cls_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ready_ff     <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_wr) begin
            if (cnt_ff == '0) begin
               ready_ff <= 1'b0;
            end
            cnt_ff <= (cnt_inc >= area) ? '0 : cnt_inc;
         end
         if (cmd.frame_done) begin
            ready_ff <= 1'b1;
         end
         if (cmd.pass_start) begin
            changed_ff <= 1'b0;
         end else if (cmd.promote) begin
            changed_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan position and per-pixel working values
   always_ff @(posedge clock) begin
      if (cmd.pass_start) begin
         x_ff   <= '0;
         y_ff   <= '0;
         ctr_ff <= '0;
      end else if (cmd.pix_next) begin
         ctr_ff <= ctr_ff + AW'(1);
         if (x_last) begin
            x_ff <= '0;
            y_ff <= y_ff + YW'(1);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
      if (cmd.cap_ctr) begin
         m_ff <= rd_ms_ff[7:0];
         s_ff <= rd_ms_ff[9:8];
      end
      if (cmd.chk_lo) begin
         supp_ff <= lo_ok && (rd_ms_ff[7:0] > m_ff);
      end
      if (cmd.nb_start) begin
         nb_ff <= 3'd0;
      end else if (cmd.nb_next) begin
         nb_ff <= nb_ff + 3'd1;
      end
      if (cmd.idx_cap) begin
         idx_ok_ff <= (IW'(pixel_index) < IW'(area));
      end
      if (cmd.edge_clr) begin
         edge_ff <= 1'b0;
      end else if (cmd.edge_cap) begin
         edge_ff <= ready_ff && idx_ok_ff && (rd_cls_ff == CLS_STRONG);
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {ready_ff, edge_ff};
      end
   end

   assign status.count_last = (cnt_inc >= area);
   assign status.interior   = (x_ff != '0) && !x_last && (y_ff != '0) && !y_last;
   assign status.ctr_weak   = (rd_cls_ff == CLS_WEAK);
   assign status.nb_strong  = (rd_cls_ff == CLS_STRONG);
   assign status.nb_last    = (nb_ff == NB_LAST);
   assign status.pix_last   = x_last && y_last;
   assign status.changed    = changed_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2)'(0), rsp_data_ff};

endmodule
`default_nettype wire

// File: rtl/edge_thinning_and_hysteresis_core.sv
// Top level of the edge thinning and hysteresis core: settings registers and wiring.
// Usage:
// Configure frame size and thresholds on the csr_ channel while the core is idle.
// Send load beats (tuser 0) with magnitude and direction in raster order; once
// width*height pixels are in, the core thins the frame and runs hysteresis.
// Send read beats (tuser 1) with a raster index to get that pixel's edge bit.
// Every request beat gives exactly one response beat carrying is_edge and
// frame_ready.
// Sequence: a load goes from acceptance to response, a read via a memory read
// state (frame memories with one write and one read port). The load that completes
// a frame also covers processing: a suppression scan of NMS_CTR, NMS_CAP, NMS_LO,
// NMS_HI and NMS_WR per pixel, then hysteresis passes of HYS_CTR and HYS_CHK per
// pixel, HYS_NB neighbour reads for weak interior ones, until a pass promotes nothing.
// One request is in flight at a time; a new beat is taken while the previous
// response still waits on rsp_tready, and the core holds off when it stalls.
// Reset empties the response register, zeroes the load count, clears
// frame_ready and restores width 256, height 256, thresholds 80 and 20.
// Frame memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module edge_thinning_and_hysteresis_core #(
   parameter int MAX_WIDTH  = eth_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = eth_pkg::DEF_MAX_HEIGHT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [7:0] magnitude, [15:8] direction, [31:16] pixel_index
   input  wire [eth_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action
   input  wire [0:0]                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [0] is_edge, [1] frame_ready, rest zero
   output logic [eth_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [eth_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [eth_pkg::CSR_DATA_W-1:0]     csr_data
);
   import eth_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CWW = (WW > DIM_REG_W) ? WW : DIM_REG_W;
   localparam int CHW = (HW > DIM_REG_W) ? HW : DIM_REG_W;

   logic [DIM_REG_W-1:0] width_ff;
   logic [DIM_REG_W-1:0] height_ff;
   logic [THR_W-1:0]     high_ff;
   logic [THR_W-1:0]     low_ff;
   logic [CWW-1:0]       wv;
   logic [CHW-1:0]       hv;
   logic [WW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   eth_cmd_type          cmd;
   eth_status_type       status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         high_ff   <= RST_HIGH;
         low_ff    <= RST_LOW;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_HIGH:   high_ff   <= csr_data[THR_W-1:0];
            CSR_LOW:    low_ff    <= csr_data[THR_W-1:0];
            default:    ;
         endcase
      end
   end

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      wv = CWW'(width_ff);
      hv = CHW'(height_ff);
      if (wv == '0) begin
         wv = CWW'(1);
      end else if (wv > CWW'(MAX_WIDTH)) begin
         wv = CWW'(MAX_WIDTH);
      end
      if (hv == '0) begin
         hv = CHW'(1);
      end else if (hv > CHW'(MAX_HEIGHT)) begin
         hv = CHW'(MAX_HEIGHT);
      end
      w_eff = WW'(wv);
      h_eff = HW'(hv);
   end

   eth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   eth_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .magnitude      (req_tdata[7:0]),
      .direction      (req_tdata[15:8]),
      .pixel_index    (req_tdata[31:16]),
      .w_eff          (w_eff),
      .h_eff          (h_eff),
      .high_threshold (high_ff),
      .low_threshold  (low_ff),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata)
   );

   // an edge can only be reported from a processed frame
   a_edge_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("edge reported without a processed frame");

   // one request in flight: no beat taken in the cycle after an accept
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on consecutive cycles");

   // a fresh response beat leaves the request side open again
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> req_tready)
      else $error("response raised while request side closed");

endmodule
`default_nettype wire

// File: tb/edge_thinning_and_hysteresis_core_tb.sv
// Self-checking testbench for the edge thinning and hysteresis core.
`timescale 1ns / 1ps
`default_nettype none
module edge_thinning_and_hysteresis_core_tb;
   import eth_pkg::*;

   localparam int QUIET_LIMIT = 200000;
   localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

   typedef struct packed {
      logic is_edge;
      logic frame_ready;
   } pixel_result_type;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  action;
      logic [7:0]            magnitude;
      logic [7:0]            direction;
      logic [15:0]           pixel_index;
      bit                    fixed;
      pixel_result_type      fixed_result;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   edge_thinning_and_hysteresis_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // shadow of the frame memories and control state
   logic [7:0]     shadow_mag [STORE_DEPTH];
   logic [1:0]     shadow_sec [STORE_DEPTH];
   logic [1:0]     shadow_cls [STORE_DEPTH];
   int             shadow_load_count;
   logic           shadow_ready;
   logic [8:0]     shadow_width, shadow_height;
   logic [7:0]     shadow_high, shadow_low;

   pixel_result_type  pending_results [$];
   directed_row_type  directed_tab [$];
   int             error_count;
   int             items_sent;
   int             results_seen;
   int             edges_seen;
   int             frames_done;
   int             send_gap_pct;
   int             stall_pct;
   int             hold_left;
   int             quiet_cycles;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic int eff_dim(input logic [8:0] v, input int maxv);
      if (v == 0) return 1;
      return (int'(v) > maxv) ? maxv : int'(v);
   endfunction

   function automatic logic [1:0] quantise_direction(input logic [7:0] dir);
      int d;
      d = (dir > 8'd180) ? int'(dir) - 180 : int'(dir);
      if (d >= 23 && d <= 67) return SEC_45;
      if (d >= 68 && d <= 112) return SEC_90;
      if (d >= 113 && d <= 157) return SEC_135;
      return SEC_0;
   endfunction

   // suppression, classification and hysteresis on the shadow frame
   task automatic thin_and_link(input int w, input int h);
      int sdx [4];
      int sdy [4];
      int work [$];
      int i, j, k, s, ni, nj, idx, m, keep, p, px, py, dx, dy, n;
      sdx = '{1, 1, 0, -1};
      sdy = '{0, 1, 1, 1};
      for (j = 0; j < h; j++) begin
         for (i = 0; i < w; i++) begin
            idx = j * w + i;
            s = shadow_sec[idx];
            m = shadow_mag[idx];
            keep = m;
            for (k = -1; k <= 1; k += 2) begin
               ni = i + k * sdx[s];
               nj = j + k * sdy[s];
               if (ni >= 0 && ni < w && nj >= 0 && nj < h && shadow_mag[nj * w + ni] > m)
                  keep = 0;
            end
            if (keep >= shadow_high) begin
               shadow_cls[idx] = CLS_STRONG;
               work.push_back(idx);
            end else if (keep >= shadow_low) begin
               shadow_cls[idx] = CLS_WEAK;
            end else begin
               shadow_cls[idx] = CLS_NONE;
            end
         end
      end
      while (work.size() > 0) begin
         p = work.pop_back();
         px = p % w;
         py = p / w;
         for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
               ni = px + dx;
               nj = py + dy;
               if (ni >= 1 && ni <= w - 2 && nj >= 1 && nj <= h - 2) begin
                  n = nj * w + ni;
                  if (shadow_cls[n] == CLS_WEAK) begin
                     shadow_cls[n] = CLS_STRONG;
                     work.push_back(n);
                  end
               end
            end
         end
      end
      for (idx = 0; idx < w * h; idx++)
         if (shadow_cls[idx] == CLS_WEAK) shadow_cls[idx] = CLS_NONE;
   endtask

   task automatic predict_beat(input logic act, input logic [7:0] m, input logic [7:0] d,
                               input logic [15:0] idx, output pixel_result_type r);
      int w, h, area;
      w = eff_dim(shadow_width, DEF_MAX_WIDTH);
      h = eff_dim(shadow_height, DEF_MAX_HEIGHT);
      area = w * h;
      r.is_edge = 1'b0;
      if (act == ACT_LOAD) begin
         if (shadow_load_count >= STORE_DEPTH) shadow_load_count = 0;
         if (shadow_load_count == 0) shadow_ready = 1'b0;
         shadow_mag[shadow_load_count] = m;
         shadow_sec[shadow_load_count] = quantise_direction(d);
         shadow_load_count++;
         if (shadow_load_count >= area) begin
            thin_and_link(w, h);
            shadow_ready = 1'b1;
            shadow_load_count = 0;
            frames_done++;
         end
      end else if (shadow_ready && int'(idx) < area && shadow_cls[idx] == CLS_STRONG) begin
         r.is_edge = 1'b1;
      end
      r.frame_ready = shadow_ready;
   endtask

   // called at a rising edge; returns at the edge that accepted the beat
   task automatic send_pixel_beat(input logic act, input logic [7:0] m, input logic [7:0] d,
                                  input logic [15:0] idx, input bit fixed,
                                  input pixel_result_type fixed_result);
      pixel_result_type r;
      if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {idx, d, m};
      do @(posedge clock); while (!req_tready);
      predict_beat(act, m, d, idx, r);
      if (fixed) r = fixed_result;
      pending_results.push_back(r);
      items_sent++;
   endtask

   task automatic drain_responses;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIDTH:  shadow_width  = v;
         CSR_HEIGHT: shadow_height = v;
         CSR_HIGH:   shadow_high   = v[7:0];
         CSR_LOW:    shadow_low    = v[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_csr_row(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      directed_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.reg_idx = idx;
      row.reg_val = v;
      directed_tab.push_back(row);
   endtask

   task automatic add_beat_row(input logic act, input logic [7:0] m, input logic [7:0] d,
                               input logic [15:0] idx, input bit fixed,
                               input logic fe, input logic fr);
      directed_row_type row;
      row = '{default: '0};
      row.action = act;
      row.magnitude = m;
      row.direction = d;
      row.pixel_index = idx;
      row.fixed = fixed;
      row.fixed_result.is_edge = fe;
      row.fixed_result.frame_ready = fr;
      directed_tab.push_back(row);
   endtask

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with nothing pending");
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata[0] !== e.is_edge)
               report_mismatch($sformatf("is_edge %b, expected %b", rsp_tdata[0], e.is_edge));
            if (rsp_tdata[1] !== e.frame_ready)
               report_mismatch($sformatf("frame_ready %b, expected %b",
                                         rsp_tdata[1], e.frame_ready));
            if (e.is_edge) edges_seen++;
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int frame_no, w, h, area, mode, p, lo;
      logic [15:0] idx;
      pixel_result_type none;
      directed_row_type row;

      none = '0;
      error_count = 0;
      items_sent = 0;
      results_seen = 0;
      edges_seen = 0;
      frames_done = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      quiet_cycles = 0;
      shadow_load_count = 0;
      shadow_ready = 1'b0;
      shadow_width = RST_WIDTH;
      shadow_height = RST_HEIGHT;
      shadow_high = RST_HIGH;
      shadow_low = RST_LOW;

      // reads before any frame, a 3x3 frame with every direction band,
      // then a shrink mid frame that completes the frame at once
      add_beat_row(ACT_READ, 8'd0, 8'd0, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_READ, 8'hFF, 8'hFF, 16'hFFFF, 1, 1'b0, 1'b0);
      add_csr_row(CSR_WIDTH, 9'd3);
      add_csr_row(CSR_HEIGHT, 9'd3);
      add_csr_row(CSR_HIGH, 9'd100);
      add_csr_row(CSR_LOW, 9'd20);
      add_beat_row(ACT_LOAD, 8'd40, 8'd0, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_READ, 8'd0, 8'd0, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd90, 8'd23, 16'hFFFF, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd255, 8'd67, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd30, 8'd68, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd0, 8'd112, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd120, 8'd113, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd60, 8'd157, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd25, 8'd158, 16'd0, 1, 1'b0, 1'b0);
      add_beat_row(ACT_LOAD, 8'd200, 8'd255, 16'd0, 1, 1'b0, 1'b1);
      add_beat_row(ACT_READ, 8'd0, 8'd0, 16'd4, 0, 1'b0, 1'b0);
      add_beat_row(ACT_READ, 8'd0, 8'd0, 16'd9, 1, 1'b0, 1'b1);
      add_beat_row(ACT_READ, 8'd0, 8'd0, 16'hFFFF, 1, 1'b0, 1'b1);
      add_csr_row(CSR_WIDTH, 9'd4);
      add_csr_row(CSR_HEIGHT, 9'd4);
      for (p = 0; p < 5; p++)
         add_beat_row(ACT_LOAD, 8'(50 * p + 5), 8'(181 + 15 * p), 16'd0, 0, 1'b0, 1'b0);
      add_csr_row(CSR_WIDTH, 9'd2);
      add_csr_row(CSR_HEIGHT, 9'd2);
      add_beat_row(ACT_LOAD, 8'd10, 8'd90, 16'd0, 0, 1'b0, 1'b0);
      add_beat_row(ACT_READ, 8'd0, 8'd0, 16'd3, 0, 1'b0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_tab[r]) begin
         row = directed_tab[r];
         if (row.is_csr) begin
            drain_responses();
            write_setting(row.reg_idx, row.reg_val);
         end else begin
            send_pixel_beat(row.action, row.magnitude, row.direction, row.pixel_index,
                            row.fixed, row.fixed_result);
         end
      end

      frame_no = 0;
      while (frame_no < 9 || items_sent < 420) begin
         drain_responses();
         mode = frame_no % 4;
         send_gap_pct = (mode == 1) ? 63 : (mode == 3) ? 25 : 0;
         stall_pct    = (mode == 2) ? 63 : (mode == 3) ? 25 : 0;
         case (frame_no)
            1: begin w = 40; h = 1; end
            2: begin w = 1; h = 40; end
            3: begin w = 1; h = 1; end
            5: begin w = 2; h = 3; end
            default: begin w = $urandom_range(3, 6); h = $urandom_range(3, 6); end
         endcase
         area = w * h;
         lo = $urandom_range(0, 60);
         write_setting(CSR_WIDTH, 9'(w));
         write_setting(CSR_HEIGHT, 9'(h));
         if (frame_no == 4) begin
            write_setting(CSR_HIGH, 9'd0);
            write_setting(CSR_LOW, 9'd0);
         end else if (frame_no == 6) begin
            write_setting(CSR_HIGH, 9'd255);
            write_setting(CSR_LOW, 9'd255);
         end else begin
            write_setting(CSR_HIGH, 9'(lo + $urandom_range(0, 120)));
            write_setting(CSR_LOW, 9'(lo));
         end
         // hold the receiver off while loads keep coming
         if (frame_no == 8) hold_left = 400;
         for (p = 0; p < area; p++) begin
            if (p > 0 && $urandom_range(0, 3) == 0)
               send_pixel_beat(ACT_READ, 8'($urandom), 8'($urandom),
                               16'($urandom_range(0, 65535)), 0, none);
            send_pixel_beat(ACT_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 0, none);
         end
         repeat (20) begin
            if ($urandom_range(0, 3) == 0) idx = 16'($urandom_range(0, 65535));
            else idx = 16'($urandom_range(0, area - 1));
            send_pixel_beat(ACT_READ, 8'($urandom), 8'($urandom), idx, 0, none);
         end
         frame_no++;
      end

      drain_responses();
      repeat (50) @(posedge clock);
      $display("covered %0d request beats and %0d response beats over %0d processed frames",
               items_sent, results_seen, frames_done);
      $display("frame sizes 1x1 to 40x1 and 1x40, thresholds 0 to 255, %0d edge pixels read",
               edges_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
